// ===== src/hrs_pkg.sv =====
// shared constants, codes and types of the heightmap resampler
package hrs_pkg;

	// fixed field widths
	localparam int COORD_W  = 12;
	localparam int SAMPLE_W = 16;
	localparam int SIZE_W   = 9;
	localparam int STEP_W   = 24;
	localparam int PROD_W   = COORD_W + STEP_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = STEP_W;

	// parameter defaults
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_FRAC_BITS  = 16;

	// register reset values
	localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 9'd256;
	localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 9'd256;
	localparam logic [STEP_W-1:0] RST_STEP       = 24'd65536;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 2'd3;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AFULL = QUEUE_DEPTH - 2;

	// sample bias that makes a signed height unsigned
	localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = 16'h8000;

	typedef struct packed {
		logic empty;
		logic almost_full;
	} hrs_q_status_t;

endpackage

// ===== src/hrs_front.sv =====
// front end: accepts items, scales query coordinates and clamps to the source
module hrs_front #(
	parameter int MAX_WIDTH  = hrs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hrs_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = hrs_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic                              op,
	input  logic [hrs_pkg::COORD_W-1:0]       coord_x,
	input  logic [hrs_pkg::COORD_W-1:0]       coord_y,
	input  logic [hrs_pkg::SAMPLE_W-1:0]      sample,
	input  logic [hrs_pkg::SIZE_W-1:0]        src_width,
	input  logic [hrs_pkg::SIZE_W-1:0]        src_height,
	input  logic [hrs_pkg::STEP_W-1:0]        step_x,
	input  logic [hrs_pkg::STEP_W-1:0]        step_y,
	output logic                              item_valid,
	output logic                              item_op,
	output logic                              item_flag,
	output logic [$clog2(MAX_WIDTH)-1:0]      item_x0,
	output logic [$clog2(MAX_WIDTH)-1:0]      item_x1,
	output logic [$clog2(MAX_HEIGHT)-1:0]     item_y0,
	output logic [$clog2(MAX_HEIGHT)-1:0]     item_y1,
	output logic [FRAC_BITS-1:0]              item_fx,
	output logic [FRAC_BITS-1:0]              item_fy,
	output logic [hrs_pkg::SAMPLE_W-1:0]      item_sample
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int IPW = hrs_pkg::PROD_W - FRAC_BITS;

	logic                          valid_s1;
	logic                          op_s1;
	logic [hrs_pkg::COORD_W-1:0]   cx_s1;
	logic [hrs_pkg::COORD_W-1:0]   cy_s1;
	logic [hrs_pkg::SAMPLE_W-1:0]  smp_s1;
	logic [hrs_pkg::PROD_W-1:0]    px_s1;
	logic [hrs_pkg::PROD_W-1:0]    py_s1;
	logic [hrs_pkg::PROD_W-1:0]    mul_x;
	logic [hrs_pkg::PROD_W-1:0]    mul_y;
	logic [XW-1:0]                 last_x;
	logic [YW-1:0]                 last_y;
	logic [IPW-1:0]                ipx;
	logic [IPW-1:0]                ipy;
	logic [IPW-1:0]                lastx_w;
	logic [IPW-1:0]                lasty_w;
	logic [FRAC_BITS-1:0]          fracx;
	logic [FRAC_BITS-1:0]          fracy;
	logic                          ovx;
	logic                          ovy;
	logic                          wclx;
	logic                          wcly;

	// position products, one per axis
	assign mul_x = coord_x * step_x;
	assign mul_y = coord_y * step_y;

	// capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= op;
			cx_s1  <= coord_x;
			cy_s1  <= coord_y;
			smp_s1 <= sample;
			px_s1  <= mul_x;
			py_s1  <= mul_y;
		end
	end

	// effective last column and row from the size registers
	always_comb begin
		if (src_width < 9'd2) begin
			last_x = XW'(1);
		end else if (32'(src_width) > MAX_WIDTH) begin
			last_x = XW'(MAX_WIDTH - 1);
		end else begin
			last_x = XW'(src_width - 9'd1);
		end
		if (src_height < 9'd2) begin
			last_y = YW'(1);
		end else if (32'(src_height) > MAX_HEIGHT) begin
			last_y = YW'(MAX_HEIGHT - 1);
		end else begin
			last_y = YW'(src_height - 9'd1);
		end
	end

	// split positions and detect edge overrun
	assign ipx     = px_s1[hrs_pkg::PROD_W-1:FRAC_BITS];
	assign ipy     = py_s1[hrs_pkg::PROD_W-1:FRAC_BITS];
	assign fracx   = px_s1[FRAC_BITS-1:0];
	assign fracy   = py_s1[FRAC_BITS-1:0];
	assign lastx_w = IPW'(last_x);
	assign lasty_w = IPW'(last_y);
	assign ovx     = (ipx > lastx_w) || ((ipx == lastx_w) && (fracx != '0));
	assign ovy     = (ipy > lasty_w) || ((ipy == lasty_w) && (fracy != '0));
	assign wclx    = cx_s1 > hrs_pkg::COORD_W'(last_x);
	assign wcly    = cy_s1 > hrs_pkg::COORD_W'(last_y);

	// classify into a write or a four-neighbor query
	always_comb begin
		item_valid  = valid_s1;
		item_op     = op_s1;
		item_sample = smp_s1;
		if (op_s1 == hrs_pkg::OP_WRITE) begin
			item_x0   = wclx ? last_x : XW'(cx_s1);
			item_x1   = item_x0;
			item_y0   = wcly ? last_y : YW'(cy_s1);
			item_y1   = item_y0;
			item_fx   = '0;
			item_fy   = '0;
			item_flag = wclx || wcly;
		end else begin
			item_x0   = ovx ? last_x : XW'(ipx);
			item_x1   = (ovx || (ipx >= lastx_w)) ? last_x : XW'(ipx) + XW'(1);
			item_y0   = ovy ? last_y : YW'(ipy);
			item_y1   = (ovy || (ipy >= lasty_w)) ? last_y : YW'(ipy) + YW'(1);
			item_fx   = ovx ? '0 : fracx;
			item_fy   = ovy ? '0 : fracy;
			item_flag = ovx || ovy;
		end
	end

endmodule

// ===== src/hrs_queue.sv =====
// short item queue between the front end and the back end
module hrs_queue #(
	parameter int WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  pop,
	output logic [WIDTH-1:0]      rdata,
	output hrs_pkg::hrs_q_status_t status
);

	localparam int DEPTH = hrs_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata              = slot_q[rd_ptr_q];
	assign status.empty       = (count_q == '0);
	assign status.almost_full = (count_q >= CW'(hrs_pkg::QUEUE_AFULL));

	// a push into a full queue must be matched by a pop
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && (count_q == CW'(DEPTH)) |-> pop)
		else $error("queue overflow");

	// never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue underflow");

endmodule

// ===== src/hrs_back.sv =====
// back end: banked height store, four-neighbor read and blend pipeline
module hrs_back #(
	parameter int MAX_WIDTH  = hrs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hrs_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = hrs_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pop,
	input  logic                              hd_op,
	input  logic                              hd_flag,
	input  logic [$clog2(MAX_WIDTH)-1:0]      hd_x0,
	input  logic [$clog2(MAX_WIDTH)-1:0]      hd_x1,
	input  logic [$clog2(MAX_HEIGHT)-1:0]     hd_y0,
	input  logic [$clog2(MAX_HEIGHT)-1:0]     hd_y1,
	input  logic [FRAC_BITS-1:0]              hd_fx,
	input  logic [FRAC_BITS-1:0]              hd_fy,
	input  logic [hrs_pkg::SAMPLE_W-1:0]      hd_sample,
	output logic                              done,
	output logic [hrs_pkg::SAMPLE_W-1:0]      height,
	output logic                              flag
);

	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int XBW    = (XW > 1) ? XW - 1 : 1;
	localparam int YBW    = (YW > 1) ? YW - 1 : 1;
	localparam int BAW    = XBW + YBW;
	localparam int BDEPTH = 1 << BAW;
	localparam int NBANK  = 4;
	localparam int SW     = hrs_pkg::SAMPLE_W;
	localparam int RW     = SW + FRAC_BITS;
	localparam int HW     = RW + 1 - SW;
	localparam int TW     = SW + 2 * FRAC_BITS;

	logic [SW-1:0]    mem [NBANK][BDEPTH];
	logic [SW-1:0]    rd_q [NBANK];
	logic [BAW-1:0]   raddr [NBANK];
	logic [NBANK-1:0] we;
	logic [BAW-1:0]   waddr;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                 op_s1, op_s2, op_s3, op_s4;
	logic                 flag_s1, flag_s2, flag_s3, flag_s4;
	logic                 x0p_s1, x1p_s1, y0p_s1, y1p_s1;
	logic [FRAC_BITS-1:0] fx_s1;
	logic [FRAC_BITS-1:0] fy_s1, fy_s2;
	logic [RW-1:0]        row0_s2, row1_s2, row0_s3;
	logic [RW-1:0]        row0_c, row1_c;
	logic [SW+FRAC_BITS-1:0] plo_s3;
	logic signed [2*FRAC_BITS+1:0] phi_s3;
	logic [TW-1:0]        sum_s4;

	logic [SW-1:0] s00, s01, s10, s11;
	logic signed [SW:0] d0, d1;
	logic signed [SW+FRAC_BITS+1:0] m0, m1;
	logic signed [RW:0] dr;
	logic [SW-1:0] dr_lo;
	logic signed [HW-1:0] dr_hi;
	logic [SW+FRAC_BITS-1:0] plo_c;
	logic signed [2*FRAC_BITS+1:0] phi_c;
	logic signed [TW+1:0] sum_c;
	logic [TW:0] rnd_c;

	// write address and bank enables
	assign waddr = {YBW'(hd_y0 >> 1), XBW'(hd_x0 >> 1)};

	// four banks split by column and row parity
	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		localparam logic PX = 1'(b % 2);
		localparam logic PY = 1'(b / 2);
		logic [XW-1:0] col;
		logic [YW-1:0] row;

		assign col      = (hd_x0[0] == PX) ? hd_x0 : hd_x1;
		assign row      = (hd_y0[0] == PY) ? hd_y0 : hd_y1;
		assign raddr[b] = {YBW'(row >> 1), XBW'(col >> 1)};
		assign we[b]    = pop && (hd_op == hrs_pkg::OP_WRITE)
			&& (hd_x0[0] == PX) && (hd_y0[0] == PY);

		always_ff @(posedge clk) begin
			if (we[b]) begin
				mem[b][waddr] <= hd_sample;
			end
			rd_q[b] <= mem[b][raddr[b]];
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done     <= valid_s4;
		end
	end

	// item details alongside the store read
	always_ff @(posedge clk) begin
		op_s1   <= hd_op;
		flag_s1 <= hd_flag;
		fx_s1   <= hd_fx;
		fy_s1   <= hd_fy;
		x0p_s1  <= hd_x0[0];
		x1p_s1  <= hd_x1[0];
		y0p_s1  <= hd_y0[0];
		y1p_s1  <= hd_y1[0];
	end

	// pick neighbors by parity and remove the sign bias
	always_comb begin
		s00 = (y0p_s1 ? (x0p_s1 ? rd_q[3] : rd_q[2]) : (x0p_s1 ? rd_q[1] : rd_q[0]))
			^ hrs_pkg::SAMPLE_BIAS;
		s01 = (y0p_s1 ? (x1p_s1 ? rd_q[3] : rd_q[2]) : (x1p_s1 ? rd_q[1] : rd_q[0]))
			^ hrs_pkg::SAMPLE_BIAS;
		s10 = (y1p_s1 ? (x0p_s1 ? rd_q[3] : rd_q[2]) : (x0p_s1 ? rd_q[1] : rd_q[0]))
			^ hrs_pkg::SAMPLE_BIAS;
		s11 = (y1p_s1 ? (x1p_s1 ? rd_q[3] : rd_q[2]) : (x1p_s1 ? rd_q[1] : rd_q[0]))
			^ hrs_pkg::SAMPLE_BIAS;
	end

	// horizontal blend of each row: s0*one + (s1-s0)*fx
	assign d0     = $signed({1'b0, s01}) - $signed({1'b0, s00});
	assign d1     = $signed({1'b0, s11}) - $signed({1'b0, s10});
	assign m0     = d0 * $signed({1'b0, fx_s1});
	assign m1     = d1 * $signed({1'b0, fx_s1});
	assign row0_c = RW'($signed({2'b00, s00, {FRAC_BITS{1'b0}}}) + m0);
	assign row1_c = RW'($signed({2'b00, s10, {FRAC_BITS{1'b0}}}) + m1);

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		flag_s2 <= flag_s1;
		fy_s2   <= fy_s1;
		row0_s2 <= row0_c;
		row1_s2 <= row1_c;
	end

	// vertical difference times fy, split into low and high partial products
	assign dr    = $signed({1'b0, row1_s2}) - $signed({1'b0, row0_s2});
	assign dr_lo = dr[SW-1:0];
	assign dr_hi = dr[RW:SW];
	assign plo_c = dr_lo * fy_s2;
	assign phi_c = dr_hi * $signed({1'b0, fy_s2});

	always_ff @(posedge clk) begin
		op_s3   <= op_s2;
		flag_s3 <= flag_s2;
		row0_s3 <= row0_s2;
		plo_s3  <= plo_c;
		phi_s3  <= phi_c;
	end

	// full weighted sum
	assign sum_c = $signed({2'b00, row0_s3, {FRAC_BITS{1'b0}}})
		+ $signed({{(FRAC_BITS + 2){1'b0}}, plo_s3})
		+ $signed({phi_s3, {SW{1'b0}}});

	always_ff @(posedge clk) begin
		op_s4   <= op_s3;
		flag_s4 <= flag_s3;
		sum_s4  <= TW'(sum_c);
	end

	// round to nearest, ties up, and restore the sign
	assign rnd_c = {1'b0, sum_s4} + ((TW + 1)'(1) << (2 * FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		flag <= flag_s4;
		if (op_s4 == hrs_pkg::OP_QUERY) begin
			height <= rnd_c[2*FRAC_BITS+SW-1:2*FRAC_BITS] ^ hrs_pkg::SAMPLE_BIAS;
		end else begin
			height <= '0;
		end
	end

	// only a popped write touches a bank, and then exactly one bank
	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(we) && ((we != '0) == (pop && (hd_op == hrs_pkg::OP_WRITE))))
		else $error("bad bank write enables");

endmodule

// ===== src/bilinear_heightmap_resampler.sv =====
// top level of the bilinear heightmap resampler
//
// Holds a source heightmap in four parity banks and answers bilinear queries.
// Input channel: an item (op, coord_x, coord_y, sample) is taken at a rising
// edge with start high and busy low. op write stores sample at a clamped
// source position; op query scales the destination point by step_x/step_y
// and blends the four neighbor samples, rounded to nearest.
// Result channel: every item gives one result on height_out and status, shown
// for one cycle with done high. done rises once the item has left the front end,
// the queue and the back-end pipe; results leave in the order the items came in.
// Throughput: one item per cycle while busy is low. The front end (scale multiply,
// clamp) feeds a four-entry queue; the back end pops one item a cycle, reads all
// four neighbors in the same cycle from the banks and blends them in a four-stage pipe.
// Configuration: cfg_we with cfg_idx and cfg_data writes a register at once;
// write it only while no item is in flight.
// Reset: clears the pipeline, queue and registers to their defaults; the
// height store keeps whatever it holds and must be written before it is read.
module bilinear_heightmap_resampler #(
	parameter int MAX_WIDTH  = hrs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hrs_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = hrs_pkg::DEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 op,
	input  logic [hrs_pkg::COORD_W-1:0]          coord_x,
	input  logic [hrs_pkg::COORD_W-1:0]          coord_y,
	input  logic signed [hrs_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 cfg_we,
	input  logic [hrs_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [hrs_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 done,
	output logic signed [hrs_pkg::SAMPLE_W-1:0]  height_out,
	output logic                                 status
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int IW = 2 + 2 * XW + 2 * YW + 2 * FRAC_BITS + hrs_pkg::SAMPLE_W;

	logic [hrs_pkg::SIZE_W-1:0] src_width_q;
	logic [hrs_pkg::SIZE_W-1:0] src_height_q;
	logic [hrs_pkg::STEP_W-1:0] step_x_q;
	logic [hrs_pkg::STEP_W-1:0] step_y_q;

	logic                          take;
	logic                          f_valid;
	logic                          f_op, f_flag;
	logic [XW-1:0]                 f_x0, f_x1;
	logic [YW-1:0]                 f_y0, f_y1;
	logic [FRAC_BITS-1:0]          f_fx, f_fy;
	logic [hrs_pkg::SAMPLE_W-1:0]  f_sample;

	logic [IW-1:0]                 q_wdata;
	logic [IW-1:0]                 q_rdata;
	hrs_pkg::hrs_q_status_t        q_status;
	logic                          pop;

	logic                          h_op, h_flag;
	logic [XW-1:0]                 h_x0, h_x1;
	logic [YW-1:0]                 h_y0, h_y1;
	logic [FRAC_BITS-1:0]          h_fx, h_fy;
	logic [hrs_pkg::SAMPLE_W-1:0]  h_sample;
	logic [hrs_pkg::SAMPLE_W-1:0]  b_height;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= hrs_pkg::RST_SRC_WIDTH;
			src_height_q <= hrs_pkg::RST_SRC_HEIGHT;
			step_x_q     <= hrs_pkg::RST_STEP;
			step_y_q     <= hrs_pkg::RST_STEP;
		end else if (cfg_we) begin
			case (cfg_idx)
				hrs_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data[hrs_pkg::SIZE_W-1:0];
				hrs_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[hrs_pkg::SIZE_W-1:0];
				hrs_pkg::REG_STEP_X:     step_x_q     <= cfg_data;
				hrs_pkg::REG_STEP_Y:     step_y_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input beat handshake
	assign busy = q_status.almost_full;
	assign take = start && !busy;

	hrs_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.op          (op),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.sample      (sample),
		.src_width   (src_width_q),
		.src_height  (src_height_q),
		.step_x      (step_x_q),
		.step_y      (step_y_q),
		.item_valid  (f_valid),
		.item_op     (f_op),
		.item_flag   (f_flag),
		.item_x0     (f_x0),
		.item_x1     (f_x1),
		.item_y0     (f_y0),
		.item_y1     (f_y1),
		.item_fx     (f_fx),
		.item_fy     (f_fy),
		.item_sample (f_sample)
	);

	// pack and unpack queue entries
	assign q_wdata = {f_op, f_flag, f_x0, f_x1, f_y0, f_y1, f_fx, f_fy, f_sample};
	assign {h_op, h_flag, h_x0, h_x1, h_y0, h_y1, h_fx, h_fy, h_sample} = q_rdata;

	hrs_queue #(
		.WIDTH (IW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	// back end takes one entry every cycle it has one
	assign pop = !q_status.empty;

	hrs_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.hd_op     (h_op),
		.hd_flag   (h_flag),
		.hd_x0     (h_x0),
		.hd_x1     (h_x1),
		.hd_y0     (h_y0),
		.hd_y1     (h_y1),
		.hd_fx     (h_fx),
		.hd_fy     (h_fy),
		.hd_sample (h_sample),
		.done      (done),
		.height    (b_height),
		.flag      (status)
	);

	assign height_out = b_height;

	// each taken item yields its result beat on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##7 done)
		else $error("result missing after accepted item");

	// no result without an item taken earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, 7))
		else $error("result without accepted item");

endmodule

// ===== tb/bilinear_heightmap_resampler_tb.sv =====
// self-checking testbench of the bilinear heightmap resampler
module bilinear_heightmap_resampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W       = hrs_pkg::DEF_MAX_WIDTH;
	localparam int MAX_H       = hrs_pkg::DEF_MAX_HEIGHT;
	localparam int FRAC_BITS   = hrs_pkg::DEF_FRAC_BITS;
	localparam int COORD_W     = hrs_pkg::COORD_W;
	localparam int SAMPLE_W    = hrs_pkg::SAMPLE_W;
	localparam int SIZE_W      = hrs_pkg::SIZE_W;
	localparam int STEP_W      = hrs_pkg::STEP_W;
	localparam int CFG_IDX_W   = hrs_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = hrs_pkg::CFG_DATA_W;
	localparam int STORE_CELLS = MAX_W * MAX_H;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		logic                       op_code;
		logic [COORD_W-1:0]         cx;
		logic [COORD_W-1:0]         cy;
		logic [SAMPLE_W-1:0]        smp;
		bit                         drain_first;
	} grid_cmd_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] height;
		logic                       status;
	} height_beat_t;

	// block ports
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       op = hrs_pkg::OP_WRITE;
	logic [COORD_W-1:0]         coord_x = '0;
	logic [COORD_W-1:0]         coord_y = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_idx = hrs_pkg::REG_SRC_WIDTH;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       done;
	logic signed [SAMPLE_W-1:0] height_out;
	logic                       status;

	// commands waiting to be driven and results waiting to arrive
	grid_cmd_t    cmd_backlog[$];
	height_beat_t height_expect_q[$];
	int unsigned  cmds_issued = 0;
	int unsigned  cmds_taken = 0;
	int unsigned  errors = 0;
	int unsigned  cycle_count = 0;

	// predictor copy of the registers and the height store
	logic [SIZE_W-1:0]   cur_width_raw = hrs_pkg::RST_SRC_WIDTH;
	logic [SIZE_W-1:0]   cur_height_raw = hrs_pkg::RST_SRC_HEIGHT;
	logic [STEP_W-1:0]   cur_step_x = hrs_pkg::RST_STEP;
	logic [STEP_W-1:0]   cur_step_y = hrs_pkg::RST_STEP;
	logic [SAMPLE_W-1:0] height_shadow [0:STORE_CELLS-1];

	// stimulus-side view of the current phase
	int unsigned    gen_w = MAX_W;
	int unsigned    gen_h = MAX_H;
	logic [STEP_W-1:0] gen_sx = hrs_pkg::RST_STEP;
	logic [STEP_W-1:0] gen_sy = hrs_pkg::RST_STEP;
	int unsigned    gen_dst_x = 8;
	int unsigned    gen_dst_y = 8;
	bit             gen_written [0:STORE_CELLS-1];

	bilinear_heightmap_resampler DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.sample     (sample),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.done       (done),
		.height_out (height_out),
		.status     (status)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < STORE_CELLS; i++) begin
			height_shadow[i] = '0;
			gen_written[i] = 1'b0;
		end
	end

	function automatic int unsigned eff_size(input logic [SIZE_W-1:0] raw,
			input int unsigned max);
		if (raw < 2) return 2;
		if (32'(raw) > max) return max;
		return 32'(raw);
	endfunction

	// scale one axis into source space; returns 1 when the position was clamped
	function automatic bit map_axis_pos(input logic [COORD_W-1:0] coord,
			input logic [STEP_W-1:0] step, input int unsigned size,
			output int unsigned lo, output int unsigned hi, output bit [63:0] frac);
		bit [63:0] last;
		bit [63:0] maxpos;
		bit [63:0] pos;
		bit        hit;
		last = 64'(size - 1);
		maxpos = last << FRAC_BITS;
		pos = 64'(coord) * 64'(step);
		hit = 1'b0;
		if (pos > maxpos) begin
			pos = maxpos;
			hit = 1'b1;
		end
		frac = pos & ((64'd1 << FRAC_BITS) - 64'd1);
		lo = 32'(pos >> FRAC_BITS);
		hi = (64'(lo) + 64'd1 > last) ? 32'(last) : lo + 1;
		return hit;
	endfunction

	function automatic bit [63:0] biased_height(input int unsigned x, input int unsigned y);
		bit [63:0] v;
		v = 64'(height_shadow[y * MAX_W + x] ^ hrs_pkg::SAMPLE_BIAS);
		return v;
	endfunction

	// expected beat of one command, updating the shadow store on a write
	function automatic height_beat_t predict_beat(input grid_cmd_t c);
		height_beat_t r;
		int unsigned  w, h, x, y, x0, x1, y0, y1;
		bit [63:0]    fx, fy, wx0, wy0, sum, rnd;
		bit           hit;
		w = eff_size(cur_width_raw, MAX_W);
		h = eff_size(cur_height_raw, MAX_H);
		hit = 1'b0;
		if (c.op_code == hrs_pkg::OP_WRITE) begin
			x = 32'(c.cx);
			y = 32'(c.cy);
			if (x > w - 1) begin
				x = w - 1;
				hit = 1'b1;
			end
			if (y > h - 1) begin
				y = h - 1;
				hit = 1'b1;
			end
			height_shadow[y * MAX_W + x] = c.smp;
			r.height = '0;
		end else begin
			hit = map_axis_pos(c.cx, cur_step_x, w, x0, x1, fx);
			hit |= map_axis_pos(c.cy, cur_step_y, h, y0, y1, fy);
			wx0 = (64'd1 << FRAC_BITS) - fx;
			wy0 = (64'd1 << FRAC_BITS) - fy;
			sum = biased_height(x0, y0) * wx0 * wy0
				+ biased_height(x1, y0) * fx * wy0
				+ biased_height(x0, y1) * wx0 * fy
				+ biased_height(x1, y1) * fx * fy;
			rnd = (sum + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
			r.height = rnd[SAMPLE_W-1:0] ^ hrs_pkg::SAMPLE_BIAS;
		end
		r.status = hit;
		return r;
	endfunction

	// driver: bursts of beats from the backlog, predictor runs on each accepted beat
	always @(posedge clk) begin
		static grid_cmd_t shown_cmd;
		static int unsigned burst_left = 0;
		static int unsigned gap_left = 0;
		bit present;
		present = start;
		if (cfg_we) begin
			case (cfg_idx)
				hrs_pkg::REG_SRC_WIDTH:  cur_width_raw = cfg_data[SIZE_W-1:0];
				hrs_pkg::REG_SRC_HEIGHT: cur_height_raw = cfg_data[SIZE_W-1:0];
				hrs_pkg::REG_STEP_X:     cur_step_x = cfg_data[STEP_W-1:0];
				hrs_pkg::REG_STEP_Y:     cur_step_y = cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
		if (arst_n && start && !busy) begin
			height_expect_q.insert(height_expect_q.size(), predict_beat(shown_cmd));
			cmds_taken++;
			present = 1'b0;
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0)
				gap_left = $urandom_range(1, 6);
		end
		if (arst_n && !present) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_backlog.size() > 0 &&
					(!cmd_backlog[0].drain_first || height_expect_q.size() == 0)) begin
				shown_cmd = cmd_backlog.pop_front();
				present = 1'b1;
				op <= shown_cmd.op_code;
				coord_x <= shown_cmd.cx;
				coord_y <= shown_cmd.cy;
				sample <= shown_cmd.smp;
				if (burst_left == 0)
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 12);
			end
		end
		start <= present;
	end

	// monitor: every done beat is checked against the oldest expectation
	always @(posedge clk) begin
		height_beat_t want;
		if (arst_n && done === 1'b1) begin
			if (height_expect_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: height %0d status %0b", $time, height_out, status);
			end else begin
				want = height_expect_q.pop_front();
				if (height_out !== want.height) begin
					errors++;
					$display("%0t: height_out mismatch: expected %0d actual %0d",
						$time, want.height, height_out);
				end
				if (status !== want.status) begin
					errors++;
					$display("%0t: status mismatch: expected %0b actual %0b",
						$time, want.status, status);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic wait_drained();
		while (cmds_taken != cmds_issued || height_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// new register setting, only once the block is idle
	task automatic set_config(input logic [SIZE_W-1:0] w_raw, input logic [SIZE_W-1:0] h_raw,
			input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy);
		logic [31:0] pad;
		wait_drained();
		pad = $urandom;
		write_reg(hrs_pkg::REG_SRC_WIDTH, {pad[CFG_DATA_W-SIZE_W-1:0], w_raw});
		pad = $urandom;
		write_reg(hrs_pkg::REG_SRC_HEIGHT, {pad[CFG_DATA_W-SIZE_W-1:0], h_raw});
		write_reg(hrs_pkg::REG_STEP_X, sx);
		write_reg(hrs_pkg::REG_STEP_Y, sy);
		gen_w = eff_size(w_raw, MAX_W);
		gen_h = eff_size(h_raw, MAX_H);
		gen_sx = sx;
		gen_sy = sy;
	endtask

	task automatic queue_write(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input logic [SAMPLE_W-1:0] smp);
		grid_cmd_t   c;
		int unsigned x, y;
		x = (32'(cx) > gen_w - 1) ? gen_w - 1 : 32'(cx);
		y = (32'(cy) > gen_h - 1) ? gen_h - 1 : 32'(cy);
		gen_written[y * MAX_W + x] = 1'b1;
		c.op_code = hrs_pkg::OP_WRITE;
		c.cx = cx;
		c.cy = cy;
		c.smp = smp;
		c.drain_first = 1'b0;
		cmd_backlog.insert(cmd_backlog.size(), c);
		cmds_issued++;
	endtask

	// a query is preceded by writes to any neighbor never written
	task automatic queue_query(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input bit drain);
		grid_cmd_t   c;
		int unsigned x0, x1, y0, y1;
		int unsigned xs[2];
		int unsigned ys[2];
		bit [63:0]   fx, fy;
		void'(map_axis_pos(cx, gen_sx, gen_w, x0, x1, fx));
		void'(map_axis_pos(cy, gen_sy, gen_h, y0, y1, fy));
		xs[0] = x0;
		xs[1] = x1;
		ys[0] = y0;
		ys[1] = y1;
		foreach (ys[j])
			foreach (xs[i])
				if (!gen_written[ys[j] * MAX_W + xs[i]])
					queue_write(COORD_W'(xs[i]), COORD_W'(ys[j]), SAMPLE_W'($urandom));
		c.op_code = hrs_pkg::OP_QUERY;
		c.cx = cx;
		c.cy = cy;
		c.smp = SAMPLE_W'($urandom);
		c.drain_first = drain;
		cmd_backlog.insert(cmd_backlog.size(), c);
		cmds_issued++;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return SIZE_W'($urandom_range(0, 1));
			1: return 9'd2;
			2: return 9'd256;
			3: return SIZE_W'($urandom_range(257, 511));
			4: return SIZE_W'($urandom_range(25, 255));
			default: return SIZE_W'($urandom_range(3, 24));
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step(input int unsigned size, input int unsigned dst);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 24'hFFFFFF;
			2: return STEP_W'($urandom);
			3: return hrs_pkg::RST_STEP;
			default: return STEP_W'(((size - 1) << FRAC_BITS) / (dst - 1));
		endcase
	endfunction

	// mostly in-grid queries and writes, the rest full-range noise
	task automatic queue_random_items(input int unsigned n);
		int unsigned target, r, qx, qy;
		target = cmds_issued + n;
		while (cmds_issued < target) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				queue_write(COORD_W'($urandom_range(0, gen_w - 1)),
					COORD_W'($urandom_range(0, gen_h - 1)), pick_sample());
			end else if (r < 36) begin
				queue_write(COORD_W'($urandom), COORD_W'($urandom), pick_sample());
			end else if (r < 88) begin
				qx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, gen_dst_x + 3)
					: $urandom_range(0, gen_dst_x - 1);
				qy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, gen_dst_y + 3)
					: $urandom_range(0, gen_dst_y - 1);
				queue_query(COORD_W'(qx), COORD_W'(qy), $urandom_range(0, 99) == 0);
			end else begin
				queue_query(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
			end
		end
	endtask

	task automatic random_phase();
		logic [SIZE_W-1:0] wr, hr;
		int unsigned       we, he;
		wr = pick_size();
		hr = pick_size();
		we = eff_size(wr, MAX_W);
		he = eff_size(hr, MAX_H);
		gen_dst_x = $urandom_range(2, 48);
		gen_dst_y = $urandom_range(2, 48);
		set_config(wr, hr, pick_step(we, gen_dst_x), pick_step(he, gen_dst_y));
	endtask

	// stimulus
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: corners, edge clamps on writes and queries
		queue_write(12'd0, 12'd0, 16'h8000);
		queue_write(12'd255, 12'd255, 16'h7FFF);
		queue_write(12'hFFF, 12'hFFF, 16'h1234);
		queue_write(12'd256, 12'd17, SAMPLE_W'($urandom));
		queue_query(12'd0, 12'd0, 1'b0);
		queue_query(12'd255, 12'd255, 1'b0);
		queue_query(12'hFFF, 12'hFFF, 1'b1);
		queue_query(12'hAAA, 12'h555, 1'b0);

		// half step: rounding ties at a positive and at a negative midpoint
		set_config(9'd4, 9'd4, 24'h008000, 24'h000000);
		queue_write(12'd0, 12'd0, 16'h0000);
		queue_write(12'd1, 12'd0, 16'h0001);
		queue_query(12'd1, 12'd0, 1'b0);
		queue_write(12'd0, 12'd0, 16'hFFFF);
		queue_write(12'd1, 12'd0, 16'h0000);
		queue_query(12'd1, 12'd0, 1'b0);

		// sizes below the minimum and zero steps
		set_config(9'd1, 9'd0, 24'h000000, 24'h000000);
		queue_query(12'hFFF, 12'hFFF, 1'b0);
		queue_query(12'd7, 12'd3, 1'b0);

		// sizes above the maximum and the largest step
		set_config(9'd511, 9'd257, 24'hFFFFFF, 24'hFFFFFF);
		queue_query(12'd0, 12'd0, 1'b0);
		queue_query(12'd1, 12'd1, 1'b0);

		// random phases
		for (int p = 0; p < 12; p++) begin
			random_phase();
			queue_random_items(140);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && height_expect_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
